// ===== src/best_fit_heap_allocator_macros.svh =====
// Assertion macros used by the allocator top module.
`ifndef BEST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define BEST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define BFHA_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("check failed: lbl");

// The consequent holds in the cycle after the antecedent.
`define BFHA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed: lbl");

`endif

// ===== src/bfha_pkg.sv =====
package bfha_pkg;

  localparam int ADDR_W = 16;
  localparam int LEN_W  = 17;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  len;
  } free_ent_t;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] start;
    logic [LEN_W-1:0]  len;
  } used_ent_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_UNKNOWN = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef enum logic {
    ACT_ALLOC   = 1'b0,
    ACT_RELEASE = 1'b1
  } action_t;

endpackage

// ===== src/bfha_free_cell.sv =====
module bfha_free_cell
  import bfha_pkg::*;
(
  input  logic      clk,
  input  logic      load,
  input  free_ent_t load_val,
  input  logic      en,
  input  free_ent_t d,
  output free_ent_t q
);

  free_ent_t ent;

  always_ff @(posedge clk) begin
    if (load) begin
      ent <= load_val;
    end else if (en) begin
      ent <= d;
    end
  end

  assign q = ent;

endmodule

// ===== src/bfha_used_cell.sv =====
module bfha_used_cell
  import bfha_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  used_ent_t d,
  output used_ent_t q
);

  used_ent_t ent;

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
    end else if (en) begin
      ent.valid <= d.valid;
    end
    if (en) begin
      ent.start <= d.start;
      ent.len   <= d.len;
    end
  end

  assign q = ent;

endmodule

// ===== src/best_fit_heap_allocator.sv =====
// Channel   Direction  Contents
// s_*       in         request: tuser action, tdata request_bytes and release_offset
// m_*       out        result: tuser status, tdata payload_offset and free_bytes
//
// Both tables are rings of cells that rotate one entry per cycle past a controller while a lap runs.
// An allocate scans the free ring, decides, laps the used ring and rewrites the rings;
// a release laps the used ring, scans the free ring, decides and rewrites the rings;
// failed items finish earlier. A zero request goes straight to its result.
// Reset leaves one free block covering the heap and no used blocks.
// A stalled result holds the block only once the next request has finished.
`include "best_fit_heap_allocator_macros.svh"
module best_fit_heap_allocator
  import bfha_pkg::*;
#(
  parameter int HEAP_BYTES      = 65536,
  parameter int HEADER_BYTES    = 16,
  parameter int MAX_FREE_BLOCKS = 32,
  parameter int MAX_USED_BLOCKS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // request_bytes[15:0], release_offset[31:16]
  input  logic [0:0]  s_tuser,  // action[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // payload_offset[15:0], free_bytes[32:16], zeros[39:33]
  output logic [1:0]  m_tuser   // status[1:0]
);

  localparam int NF    = MAX_FREE_BLOCKS;
  localparam int NU    = MAX_USED_BLOCKS;
  localparam int NMAX  = (NF > NU) ? NF : NU;
  localparam int IW    = $clog2(NMAX + 1);
  localparam int SW    = LEN_W + 1;
  localparam logic [SW-1:0] HDR = SW'(HEADER_BYTES);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_FSCAN  = 6'b000010,
    S_ULAP   = 6'b000100,
    S_DECIDE = 6'b001000,
    S_FWRITE = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state;
  logic [IW-1:0] j;
  logic act;
  logic [ADDR_W-1:0] req, rel;
  logic [IW-1:0] count, count_pend;
  logic [LEN_W-1:0] free_bytes, fb_pend;
  status_t res_status;
  logic [ADDR_W-1:0] res_offset;

  free_ent_t fcell [NF];
  free_ent_t fpush, hold;
  used_ent_t ucell [NU];
  used_ent_t upush, unew;
  logic fen, uen, lap_end;

  logic found, pfound, prev_ok, ufound;
  free_ent_t best, prev, nxt;
  logic [IW-1:0] best_idx, pos, uidx;
  logic [ADDR_W-1:0] bstart;
  logic [LEN_W-1:0] blen;

  logic wr_en, del_en, ins_en;
  logic [IW-1:0] wr_idx, del_idx;
  free_ent_t wr_val;

  logic [SW-1:0] end_b, end_prev, rem;
  logic merge_next, merge_prev;
  logic [IW-1:0] pos_eff;

  assign fen = (state == S_FSCAN || state == S_FWRITE) && (j < IW'(NF));
  assign uen = (state == S_ULAP || state == S_FWRITE) && (j < IW'(NU));

  always_comb begin
    lap_end = 1'b0;
    unique case (state)
      S_FSCAN:  lap_end = (j == IW'(NF - 1));
      S_ULAP:   lap_end = (j == IW'(NU - 1));
      S_FWRITE: lap_end = (j == IW'(NMAX - 1));
      default:  lap_end = 1'b0;
    endcase
  end

  always_comb begin
    fpush = fcell[0];
    if (state == S_FWRITE) begin
      if (ins_en) begin
        if (j == wr_idx) begin
          fpush = wr_val;
        end else if (j > wr_idx) begin
          fpush = hold;
        end
      end else if (del_en && j >= del_idx) begin
        fpush = fcell[1];
      end else if (wr_en && j == wr_idx) begin
        fpush = wr_val;
      end
    end
  end

  always_comb begin
    upush = ucell[0];
    if (state == S_ULAP && act == ACT_ALLOC && !ufound && !ucell[0].valid) begin
      upush = unew;
    end else if (state == S_FWRITE && act == ACT_RELEASE && j == uidx) begin
      upush.valid = 1'b0;
    end
  end

  for (genvar i = 0; i < NF; i++) begin : g_free
    free_ent_t d;
    free_ent_t init;
    assign d    = (i == NF - 1) ? fpush : fcell[(i + 1) % NF];
    assign init = '{start: '0, len: LEN_W'(HEAP_BYTES - HEADER_BYTES)};
    bfha_free_cell u_cell (
      .clk      (clk),
      .load     (rst && (i == 0)),
      .load_val (init),
      .en       (fen),
      .d        (d),
      .q        (fcell[i])
    );
  end

  for (genvar i = 0; i < NU; i++) begin : g_used
    used_ent_t d;
    assign d = (i == NU - 1) ? upush : ucell[(i + 1) % NU];
    bfha_used_cell u_cell (
      .clk (clk),
      .rst (rst),
      .en  (uen),
      .d   (d),
      .q   (ucell[i])
    );
  end

  assign pos_eff    = pfound ? pos : count;
  assign end_b      = SW'(bstart) + HDR + SW'(blen);
  assign end_prev   = SW'(prev.start) + HDR + SW'(prev.len);
  assign merge_next = pfound && (end_b == SW'(nxt.start));
  assign merge_prev = prev_ok && (end_prev == SW'(bstart));
  assign rem        = SW'(best.len) - SW'(req);

  always_ff @(posedge clk) begin
    if (fen) begin
      hold <= fcell[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      j          <= '0;
      count      <= IW'(1);
      free_bytes <= LEN_W'(HEAP_BYTES - HEADER_BYTES);
      m_tvalid   <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            act        <= s_tuser[0];
            req        <= s_tdata[15:0];
            rel        <= s_tdata[31:16];
            j          <= '0;
            found      <= 1'b0;
            pfound     <= 1'b0;
            prev_ok    <= 1'b0;
            ufound     <= 1'b0;
            wr_en      <= 1'b0;
            del_en     <= 1'b0;
            ins_en     <= 1'b0;
            res_offset <= '0;
            res_status <= ST_OK;
            if (s_tuser[0] == ACT_RELEASE) begin
              state <= S_ULAP;
            end else if (s_tdata[15:0] == '0) begin
              res_status <= ST_NOFIT;
              state      <= S_DONE;
            end else begin
              state <= S_FSCAN;
            end
          end
        end
        S_FSCAN: begin
          if (j < count) begin
            if (act == ACT_ALLOC) begin
              if (fcell[0].len >= LEN_W'(req) && (!found || fcell[0].len < best.len)) begin
                found    <= 1'b1;
                best     <= fcell[0];
                best_idx <= j;
              end
            end else if (!pfound) begin
              if (fcell[0].start > bstart) begin
                pfound <= 1'b1;
                pos    <= j;
                nxt    <= fcell[0];
              end else begin
                prev    <= fcell[0];
                prev_ok <= 1'b1;
              end
            end
          end
          j <= lap_end ? '0 : j + IW'(1);
          if (lap_end) begin
            state <= S_DECIDE;
          end
        end
        S_ULAP: begin
          if (!ufound) begin
            if (act == ACT_ALLOC && !ucell[0].valid) begin
              ufound <= 1'b1;
            end else if (act == ACT_RELEASE && ucell[0].valid &&
                         (LEN_W'(ucell[0].start) + LEN_W'(HEADER_BYTES) == LEN_W'(rel))) begin
              ufound <= 1'b1;
              uidx   <= j;
              bstart <= ucell[0].start;
              blen   <= ucell[0].len;
            end
          end
          j <= lap_end ? '0 : j + IW'(1);
          if (lap_end) begin
            if (act == ACT_ALLOC) begin
              if (ufound || !ucell[0].valid) begin
                res_offset <= best.start + ADDR_W'(HEADER_BYTES);
                state      <= S_FWRITE;
              end else begin
                res_status <= ST_FULL;
                state      <= S_DONE;
              end
            end else if (ufound || (ucell[0].valid &&
                         (LEN_W'(ucell[0].start) + LEN_W'(HEADER_BYTES) == LEN_W'(rel)))) begin
              state <= S_FSCAN;
            end else begin
              res_status <= ST_UNKNOWN;
              state      <= S_DONE;
            end
          end
        end
        S_DECIDE: begin
          if (act == ACT_ALLOC) begin
            if (!found) begin
              res_status <= ST_NOFIT;
              state      <= S_DONE;
            end else begin
              unew.valid <= 1'b1;
              unew.start <= best.start;
              if (rem >= SW'(2 * HEADER_BYTES + 1)) begin
                wr_en        <= 1'b1;
                wr_idx       <= best_idx;
                wr_val.start <= ADDR_W'(SW'(best.start) + HDR + SW'(req));
                wr_val.len   <= LEN_W'(rem - HDR);
                unew.len     <= LEN_W'(req);
                fb_pend      <= LEN_W'(SW'(free_bytes) - SW'(req) - HDR);
                count_pend   <= count;
              end else begin
                del_en     <= 1'b1;
                del_idx    <= best_idx;
                unew.len   <= best.len;
                fb_pend    <= free_bytes - best.len;
                count_pend <= count - IW'(1);
              end
              state <= S_ULAP;
            end
          end else begin
            if (!merge_next && !merge_prev && count >= IW'(NF)) begin
              res_status <= ST_FULL;
              state      <= S_DONE;
            end else begin
              state <= S_FWRITE;
              wr_en <= 1'b1;
              if (merge_prev && merge_next) begin
                wr_idx       <= pos_eff - IW'(1);
                wr_val.start <= prev.start;
                wr_val.len   <= LEN_W'(end_b - SW'(bstart) + SW'(prev.len) + HDR + SW'(nxt.len));
                del_en       <= 1'b1;
                del_idx      <= pos_eff;
                fb_pend      <= LEN_W'(SW'(free_bytes) + SW'(blen) + HDR + HDR);
                count_pend   <= count - IW'(1);
              end else if (merge_prev) begin
                wr_idx       <= pos_eff - IW'(1);
                wr_val.start <= prev.start;
                wr_val.len   <= LEN_W'(SW'(prev.len) + HDR + SW'(blen));
                fb_pend      <= LEN_W'(SW'(free_bytes) + SW'(blen) + HDR);
                count_pend   <= count;
              end else if (merge_next) begin
                wr_idx       <= pos_eff;
                wr_val.start <= bstart;
                wr_val.len   <= LEN_W'(SW'(blen) + HDR + SW'(nxt.len));
                fb_pend      <= LEN_W'(SW'(free_bytes) + SW'(blen) + HDR);
                count_pend   <= count;
              end else begin
                ins_en       <= 1'b1;
                wr_idx       <= pos_eff;
                wr_val.start <= bstart;
                wr_val.len   <= blen;
                fb_pend      <= LEN_W'(SW'(free_bytes) + SW'(blen));
                count_pend   <= count + IW'(1);
              end
            end
          end
        end
        S_FWRITE: begin
          j <= lap_end ? '0 : j + IW'(1);
          if (lap_end) begin
            free_bytes <= fb_pend;
            count      <= count_pend;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= res_status;
            m_tdata  <= {7'd0, free_bytes, res_offset};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign s_tready = (state == S_IDLE);

  `BFHA_ASSERT_ALWAYS(a_count_range, (count >= IW'(1) || free_bytes == '0) && count <= IW'(NF))
  `BFHA_ASSERT_ALWAYS(a_free_bound, free_bytes <= LEN_W'(HEAP_BYTES - HEADER_BYTES))
  `BFHA_ASSERT_NEXT(a_start, s_tvalid && s_tready, state == S_FSCAN || state == S_ULAP || state == S_DONE)
  `BFHA_ASSERT_NEXT(a_write_done, state == S_FWRITE && lap_end, state == S_DONE && count == $past(count_pend))

endmodule
